FILE: src/dds_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal square root.
`default_nettype none
package dds_pkg;

	localparam int unsigned RAD_W  = 64;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned CAND_W = 34;
	localparam int unsigned POS_W  = 4;

	localparam logic [POS_W-1:0] TOP_POSITION = 4'd9;
	localparam logic [POS_W-1:0] DIGIT_MAX    = 4'd9;

	typedef struct packed {
		logic              vld;
		logic              ovf;
		logic [RAD_W-1:0]  sq;
	} sq_res_t;

	function automatic logic [ROOT_W-1:0] pow10(input logic [POS_W-1:0] p);
		logic [ROOT_W-1:0] v;
		case (p)
			4'd0:    v = 32'd1;
			4'd1:    v = 32'd10;
			4'd2:    v = 32'd100;
			4'd3:    v = 32'd1000;
			4'd4:    v = 32'd10000;
			4'd5:    v = 32'd100000;
			4'd6:    v = 32'd1000000;
			4'd7:    v = 32'd10000000;
			4'd8:    v = 32'd100000000;
			4'd9:    v = 32'd1000000000;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: src/dds_square.sv
// Shared registered squarer: one trial candidate squared per cycle.
`default_nettype none
module dds_square
	import dds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              issue,
	input  wire logic [CAND_W-1:0] operand,
	output sq_res_t                res
);

	logic              vld_s1;
	logic              ovf_s1;
	logic [RAD_W-1:0]  sq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s1 <= |operand[CAND_W-1:ROOT_W];
		sq_s1  <= RAD_W'(operand[ROOT_W-1:0]) * RAD_W'(operand[ROOT_W-1:0]);
	end

	assign res.vld = vld_s1;
	assign res.ovf = ovf_s1;
	assign res.sq  = sq_s1;

endmodule
`default_nettype wire

FILE: src/decimal_digit_square_root.sv
// Decimal digit-by-digit square root: command port, sequencer and shared squarer.
`default_nettype none
// A command is taken on start while busy is low; the result appears on root and
// negative_input for exactly one cycle with done high, and cannot be held off.
// A negative or zero radicand answers in the cycle after start is taken. Otherwise
// one shared 32x32 squarer tests one candidate per cycle, apart from the gaps
// while it is reseeded: the leading-position search squares successive powers
// of ten speculatively, then each decimal position takes its digit trials (up
// to nine) and a reseed of the squarer, with done in the cycle after the last
// busy cycle. busy stays high until then.
module decimal_digit_square_root
	import dds_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic signed [RAD_W-1:0] radicand,
	output logic                         done,
	output logic [ROOT_W-1:0]            root,
	output logic                         negative_input
);

	localparam int unsigned TW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {IDLE, LEAD, SEED, TRY} state_t;

	state_t             state_q;
	logic [RAD_W-1:0]   raw_q;
	logic [ROOT_W-1:0]  root_q;
	logic [ROOT_W-1:0]  step_q;
	logic [CAND_W-1:0]  cand_q;
	logic [CAND_W-1:0]  cand_s1;
	logic [POS_W-1:0]   dig_q;
	logic [POS_W-1:0]   dig_s1;
	logic [POS_W-1:0]   iss_q;
	logic [POS_W-1:0]   pos_q;
	logic [TW-1:0]      tried_q;
	logic               issue_q;
	logic               done_q;
	logic               neg_q;

	sq_res_t            sq_res;
	logic               fits;
	logic               exact;
	logic               end_pos;
	logic               finish;

	dds_square u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue_q),
		.operand (cand_q),
		.res     (sq_res)
	);

	assign fits    = !sq_res.ovf && (sq_res.sq <= raw_q);
	assign exact   = !sq_res.ovf && (sq_res.sq == raw_q);
	assign end_pos = !fits || exact || (dig_s1 == DIGIT_MAX);
	assign finish  = exact || (pos_q == '0) || (tried_q == TW'(MAX_DIGITS - 1));

	always_ff @(posedge clk) begin
		cand_s1 <= cand_q;
		dig_s1  <= dig_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			issue_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					issue_q <= 1'b0;
					if (start) begin
						raw_q   <= RAD_W'(radicand);
						root_q  <= '0;
						neg_q   <= radicand[RAD_W-1];
						pos_q   <= '0;
						tried_q <= '0;
						if (radicand[RAD_W-1] || (radicand == '0)) begin
							done_q <= 1'b1;
						end else begin
							iss_q   <= 4'd1;
							cand_q  <= CAND_W'(pow10(4'd1));
							issue_q <= 1'b1;
							state_q <= LEAD;
						end
					end
				end
				LEAD: begin
					// keep squaring the next power of ten speculatively
					if (iss_q < TOP_POSITION) begin
						iss_q   <= iss_q + 4'd1;
						cand_q  <= CAND_W'(pow10(iss_q + 4'd1));
						issue_q <= 1'b1;
					end else begin
						issue_q <= 1'b0;
					end
					if (sq_res.vld) begin
						if (fits) begin
							pos_q <= pos_q + 4'd1;
							if (pos_q + 4'd1 == TOP_POSITION) begin
								issue_q <= 1'b0;
								state_q <= SEED;
							end
						end else begin
							issue_q <= 1'b0;
							state_q <= SEED;
						end
					end
				end
				SEED: begin
					step_q  <= pow10(pos_q);
					cand_q  <= CAND_W'(root_q) + CAND_W'(pow10(pos_q));
					dig_q   <= 4'd1;
					issue_q <= 1'b1;
					state_q <= TRY;
				end
				TRY: begin
					if (dig_q < DIGIT_MAX) begin
						cand_q  <= cand_q + CAND_W'(step_q);
						dig_q   <= dig_q + 4'd1;
						issue_q <= 1'b1;
					end else begin
						issue_q <= 1'b0;
					end
					if (sq_res.vld) begin
						if (fits) begin
							root_q <= cand_s1[ROOT_W-1:0];
						end
						if (end_pos) begin
							issue_q <= 1'b0;
							if (finish) begin
								done_q  <= 1'b1;
								state_q <= IDLE;
							end else begin
								pos_q   <= pos_q - 4'd1;
								tried_q <= tried_q + TW'(1);
								state_q <= SEED;
							end
						end
					end
				end
				default: begin
					issue_q <= 1'b0;
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != IDLE);
	assign done           = done_q;
	assign root           = root_q;
	assign negative_input = neg_q;

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for decimal_digit_square_root: random and directed radicands, checked by a predictor.
`timescale 1ns / 1ps
module tb;
	import dds_pkg::*;

	localparam int unsigned MAX_DIGITS  = 16;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RANDOM_BEATS = 900;
	localparam int unsigned MAX_GAP     = 18;

	typedef struct {
		logic [RAD_W-1:0] value;
		int unsigned      gap;
		bit               drain;
	} radicand_beat_t;

	typedef struct {
		logic [ROOT_W-1:0] root;
		logic              neg;
	} root_expect_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic signed [RAD_W-1:0] radicand = '0;
	logic                    busy;
	logic                    done;
	logic [ROOT_W-1:0]       root;
	logic                    negative_input;

	radicand_beat_t pending_radicands [$];
	root_expect_t   expected_roots [$];
	int unsigned    in_flight;
	int unsigned    gap_left;
	int unsigned    held_gap;
	int unsigned    mismatches;
	int unsigned    roots_checked;
	int unsigned    negatives_checked;
	int unsigned    quiet_cycles;

	decimal_digit_square_root #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.radicand(radicand),
		.done(done),
		.root(root),
		.negative_input(negative_input)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic root_expect_t predict_root(logic [RAD_W-1:0] value);
		root_expect_t      res;
		logic [RAD_W-1:0]  pw [0:9];
		logic [RAD_W-1:0]  acc;
		logic [RAD_W-1:0]  cand;
		logic [RAD_W-1:0]  keep;
		logic [RAD_W-1:0]  d;
		int                lead;
		int                i;
		int unsigned       tried;
		bit                exact;
		res.neg  = value[RAD_W-1];
		res.root = '0;
		if (value[RAD_W-1]) begin
			return res;
		end
		pw[0] = 1;
		for (i = 1; i < 10; i++) begin
			pw[i] = pw[i-1] * 10;
		end
		acc   = '0;
		exact = 1'b0;
		if (value != 0) begin
			lead = 0;
			while (lead < 9 && pw[lead+1] * pw[lead+1] <= value) begin
				lead++;
			end
			tried = 0;
			while (tried < MAX_DIGITS && lead >= 0 && !exact) begin
				keep = '0;
				for (d = 1; d < 10; d++) begin
					cand = acc + d * pw[lead];
					if (cand > 64'hFFFF_FFFF || cand * cand > value) begin
						break;
					end
					keep = d;
					if (cand * cand == value) begin
						exact = 1'b1;
						break;
					end
				end
				acc = acc + keep * pw[lead];
				lead--;
				tried++;
			end
		end
		res.root = acc[ROOT_W-1:0];
		return res;
	endfunction

	function automatic logic [RAD_W-1:0] random_radicand();
		logic [RAD_W-1:0] v;
		logic [RAD_W-1:0] r;
		logic [RAD_W-1:0] p;
		int unsigned      k;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = {$urandom, $urandom};
			end
			2, 3: begin
				r = $urandom_range(0, 32'd3037000499);
				v = r * r + $urandom_range(0, 2) - 1;
			end
			4, 5: begin
				v = {$urandom, $urandom} >> $urandom_range(1, 63);
			end
			6: begin
				v = {1'b1, 31'($urandom), $urandom};
			end
			7: begin
				k = $urandom_range(0, 9);
				p = 1;
				repeat (k) p = p * 10;
				v = p * p + $urandom_range(0, 4) - 2;
			end
			default: begin
				v = {1'b0, 31'($urandom), $urandom};
			end
		endcase
		return v;
	endfunction

	task automatic queue_radicand(logic [RAD_W-1:0] value, int unsigned gap, bit drain);
		radicand_beat_t beat;
		beat.value = value;
		beat.gap   = gap;
		beat.drain = drain;
		pending_radicands.push_back(beat);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		radicand_beat_t beat;
		bit             taken;
		bit             start_n;
		int unsigned    flight_n;
		int unsigned    gap_n;
		if (!arst_n) begin
			start     <= 1'b0;
			radicand  <= '0;
			in_flight <= 0;
			gap_left  <= 0;
			held_gap  <= 0;
		end else begin
			taken    = start && !busy;
			flight_n = in_flight + (taken ? 1 : 0) - (done ? 1 : 0);
			start_n  = start && !taken;
			gap_n    = taken ? held_gap : gap_left;
			if (!start_n) begin
				if (gap_n != 0) begin
					gap_n--;
				end else if (pending_radicands.size() != 0 &&
						!(pending_radicands[0].drain && flight_n != 0)) begin
					beat = pending_radicands.pop_front();
					radicand <= beat.value;
					held_gap <= beat.gap;
					start_n  = 1'b1;
				end
			end
			start     <= start_n;
			in_flight <= flight_n;
			gap_left  <= gap_n;
		end
	end

	// monitor and watchdog
	always @(posedge clk or negedge arst_n) begin : check_proc
		root_expect_t exp_beat;
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (start && !busy) begin
				expected_roots.push_back(predict_root(radicand));
			end
			if (done) begin
				roots_checked++;
				if (expected_roots.size() == 0) begin
					$error("result beat with no radicand pending: root %0d neg %0b",
						root, negative_input);
					mismatches++;
				end else begin
					exp_beat = expected_roots.pop_front();
					if (exp_beat.neg) begin
						negatives_checked++;
					end
					if (root !== exp_beat.root) begin
						$error("root: expected %0d, got %0d", exp_beat.root, root);
						mismatches++;
					end
					if (negative_input !== exp_beat.neg) begin
						$error("negative_input: expected %0b, got %0b",
							exp_beat.neg, negative_input);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("tb failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus_proc
		logic [RAD_W-1:0] r;
		int unsigned      n;
		bit               burst;
		mismatches        = 0;
		roots_checked     = 0;
		negatives_checked = 0;

		r = 64'd3037000499;
		queue_radicand(64'd0, 0, 1'b0);
		queue_radicand(64'd1, 0, 1'b0);
		queue_radicand(64'd2, 3, 1'b0);
		queue_radicand(64'd3, 0, 1'b0);
		queue_radicand(64'd4, 0, 1'b0);
		queue_radicand(64'd15, 1, 1'b0);
		queue_radicand(64'd16, 0, 1'b0);
		queue_radicand(64'd99, 0, 1'b0);
		queue_radicand(64'd100, 0, 1'b0);
		queue_radicand(64'd101, 7, 1'b0);
		queue_radicand(64'd9999, 0, 1'b0);
		queue_radicand(64'd10000, 0, 1'b0);
		queue_radicand(64'd20000, 0, 1'b0);
		queue_radicand(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
		queue_radicand(64'h8000_0000_0000_0000, 0, 1'b0);
		queue_radicand(64'h7FFF_FFFF_FFFF_FFFF, 2, 1'b0);
		queue_radicand(64'd999999999999999999, 0, 1'b0);
		queue_radicand(64'd1000000000000000000, 0, 1'b0);
		queue_radicand(64'd1000000000000000001, 0, 1'b0);
		queue_radicand(r * r, 0, 1'b0);
		queue_radicand(r * r - 1, 0, 1'b0);
		queue_radicand(r * r + 1, 0, 1'b0);
		queue_radicand(64'h4000_0000_0000_0000, 0, 1'b0);
		queue_radicand(64'hAAAA_AAAA_5555_5555, 0, 1'b0);
		queue_radicand(64'h5555_5555_AAAA_AAAA, 0, 1'b1);

		burst = 1'b0;
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 60 == 0) begin
				burst = ($urandom_range(0, 2) == 0);
			end
			queue_radicand(random_radicand(),
				burst ? 0 : $urandom_range(0, MAX_GAP), (n % 150 == 75));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_radicands.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_roots.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);

		$display("checked %0d roots over directed edge values and %0d random radicands,",
			roots_checked, RANDOM_BEATS);
		$display("%0d of them negative, with bursts, random gaps and drained pauses",
			negatives_checked);
		if (mismatches == 0 && expected_roots.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/dds_pkg.sv
src/dds_square.sv
src/decimal_digit_square_root.sv
test/tb.sv
